// ----- src/aip_pkg.sv -----
// Package for the ASCII integer parser: parse phases, item and result structs,
// character constants and the character-to-digit decode. No dependencies.
package aip_pkg;

    localparam int CH_WIDTH     = 8;
    localparam int BASE_WIDTH   = 6;
    localparam int VALUE_WIDTH  = 64;
    localparam int OFFSET_WIDTH = 16;

    localparam logic [CH_WIDTH-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_WIDTH-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_WIDTH-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_WIDTH-1:0] CH_ONE     = 8'h31;
    localparam logic [CH_WIDTH-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_WIDTH-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_WIDTH-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CH_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CH_WIDTH-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_WIDTH-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CH_WIDTH-1:0] CH_LOWER_Z = 8'h7A;

    localparam logic [BASE_WIDTH-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_WIDTH-1:0] LETTER_OFS = 6'd10;

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIGN,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS
    } aip_phase_t;

    typedef struct packed {
        logic [CH_WIDTH-1:0] ch;
        logic                start_req;
    } aip_item_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  value;
        logic [OFFSET_WIDTH-1:0] end_offset;
        logic                    converted;
    } aip_result_t;

    typedef struct packed {
        logic                  valid;
        logic [BASE_WIDTH-1:0] value;
    } aip_digit_t;

    // Value of an alphanumeric character; valid is low for anything else.
    function automatic aip_digit_t digit_of(logic [CH_WIDTH-1:0] c);
        aip_digit_t r;
        r.valid = 1'b1;
        r.value = '0;
        priority if (c >= CH_ZERO && c <= CH_NINE)
        begin
            r.value = BASE_WIDTH'(c - CH_ZERO);
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            r.value = BASE_WIDTH'(c - CH_LOWER_A) + LETTER_OFS;
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r.value = BASE_WIDTH'(c - CH_UPPER_A) + LETTER_OFS;
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- src/ascii_integer_parser_top.sv -----
// Top level of the ASCII integer parser: stream ports, input and result
// registers and the radix register. Depends on aip_pkg and aip_core.
//
// Usage: characters of a string arrive one request at a time on the s_axis
// channel, ch in tdata and start_req in tuser; start_req high marks the first
// character of a new string and abandons any string still open. A string is
// an optional sign, an optional radix prefix when the radix register is zero,
// and digits. The first character that is not a valid digit closes the number
// and produces one result request on m_axis: the signed 64-bit value and the
// 16-bit end offset in tdata, the converted flag in tuser. Characters that
// arrive while no string is open are dropped without a result.
// The closing character is captured in the input register when accepted, and
// the parse step then writes the result register that drives m_axis_tvalid.
// Throughput is one character per cycle while results are taken, set by the
// combinational multiply-add by the radix in the parse core. While a result
// waits with m_axis_tready low, the parse step stalls; the input register
// still takes one more character, then s_axis_tready drops until the result
// is taken. Reset clears all control state and sets the radix to ten; the
// radix is written through cfg_we and cfg_wdata and sampled at string start.
module ascii_integer_parser_top #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Radix register write.
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    // Character requests.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic [0:0]  s_axis_tuser,   // [0] start_req
    // Result requests.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [63:0] value, [79:64] end_offset
    output logic [0:0]  m_axis_tuser    // [0] converted
);

    logic [aip_pkg::BASE_WIDTH-1:0] number_base_reg;
    aip_pkg::aip_item_t             in_item_reg;
    logic                           in_valid_reg;
    aip_pkg::aip_result_t           out_result_reg;
    logic                           out_valid_reg;

    logic                           out_can_load;
    logic                           step_en;
    logic                           core_result_valid;
    aip_pkg::aip_result_t           core_result;

    // The result register can take a new result when empty or being drained.
    assign out_can_load  = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && out_can_load;
    assign s_axis_tready = !in_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= aip_pkg::BASE_DEC;
        end
        else if (cfg_we)
        begin
            number_base_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.ch        <= s_axis_tdata;
            in_item_reg.start_req <= s_axis_tuser[0];
        end
    end

    aip_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .item         (in_item_reg),
        .number_base  (number_base_reg),
        .result_valid (core_result_valid),
        .result       (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_can_load)
        begin
            out_valid_reg <= step_en && core_result_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && core_result_valid)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_result_reg.end_offset, out_result_reg.value};
    assign m_axis_tuser  = out_result_reg.converted;

    // The input side only stalls behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // A pending character is processed in the cycle the result side frees up.
    a_step_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |-> step_en)
        else $error("parse step held with result register empty");

    // A stalled result stays valid and unchanged until it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

// ----- src/aip_core.sv -----
// Parse core of the ASCII integer parser: phase machine, accumulator and
// position registers, one character per step. Depends on aip_pkg.
module aip_core #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step_en,
    input  aip_pkg::aip_item_t                  item,
    input  logic [aip_pkg::BASE_WIDTH-1:0]      number_base,
    output logic                                result_valid,
    output aip_pkg::aip_result_t                result
);

    typedef struct packed {
        logic                           set_neg;
        logic                           bump;
        logic                           accumulate;
        logic                           finish_zero;
        logic                           finish_acc;
        logic [aip_pkg::BASE_WIDTH-1:0] base_value;
    } aip_action_t;

    aip_pkg::aip_phase_t                  phase_reg, phase_next;
    logic                                 neg_reg, neg_next;
    logic [aip_pkg::BASE_WIDTH-1:0]       base_reg, base_next;
    logic [aip_pkg::VALUE_WIDTH-1:0]      acc_reg, acc_next;
    logic [POSITION_WIDTH-1:0]            pos_reg, pos_next;
    logic                                 seen_reg, seen_next;

    aip_action_t                          act;
    aip_pkg::aip_digit_t                  dg;
    logic                                 neg_base, seen_base;
    logic [aip_pkg::VALUE_WIDTH-1:0]      acc_base;
    logic [POSITION_WIDTH-1:0]            pos_base;
    logic [aip_pkg::VALUE_WIDTH+aip_pkg::BASE_WIDTH-1:0] product;
    logic [31:0]                          pos_wide;

    assign dg = aip_pkg::digit_of(item.ch);

    // Next phase and the actions of this step. The phases fall through in
    // one step, so a character can pass sign, prefix and digit checks at once.
    always_comb
    begin
        aip_pkg::aip_phase_t            ph;
        logic [aip_pkg::BASE_WIDTH-1:0] b;
        logic                           done;
        ph   = item.start_req ? aip_pkg::PH_SIGN : phase_reg;
        b    = item.start_req ? number_base : base_reg;
        done = 1'b0;
        act  = '0;

        if (ph == aip_pkg::PH_SIGN)
        begin
            ph = aip_pkg::PH_PREFIX;
            if (item.ch == aip_pkg::CH_PLUS || item.ch == aip_pkg::CH_MINUS)
            begin
                act.set_neg = (item.ch == aip_pkg::CH_MINUS);
                act.bump    = 1'b1;
                done        = 1'b1;
            end
        end

        if (!done && ph == aip_pkg::PH_PREFIX)
        begin
            priority if (b != aip_pkg::BASE_AUTO)
            begin
                ph = aip_pkg::PH_DIGITS;
            end
            else if (item.ch == aip_pkg::CH_ZERO)
            begin
                act.bump = 1'b1;
                ph       = aip_pkg::PH_ZERO;
                done     = 1'b1;
            end
            else if (item.ch >= aip_pkg::CH_ONE && item.ch <= aip_pkg::CH_NINE)
            begin
                b  = aip_pkg::BASE_DEC;
                ph = aip_pkg::PH_DIGITS;
            end
            else
            begin
                act.finish_zero = 1'b1;
                ph              = aip_pkg::PH_IDLE;
                done            = 1'b1;
            end
        end

        if (!done && ph == aip_pkg::PH_ZERO)
        begin
            ph = aip_pkg::PH_DIGITS;
            if (item.ch == aip_pkg::CH_LOWER_X || item.ch == aip_pkg::CH_UPPER_X)
            begin
                b        = aip_pkg::BASE_HEX;
                act.bump = 1'b1;
                done     = 1'b1;
            end
            else
            begin
                b = aip_pkg::BASE_OCT;
            end
        end

        if (!done && ph == aip_pkg::PH_DIGITS)
        begin
            if (dg.valid && dg.value < b)
            begin
                act.accumulate = 1'b1;
                act.bump       = 1'b1;
            end
            else
            begin
                act.finish_acc = 1'b1;
                ph             = aip_pkg::PH_IDLE;
            end
            done = 1'b1;
        end

        if (!done)
        begin
            ph = aip_pkg::PH_IDLE;
        end

        act.base_value = b;
        phase_next     = ph;
    end

    // Datapath: one multiply-add by the radix, saturating position count
    // and the result fields.
    always_comb
    begin
        neg_base  = item.start_req ? 1'b0 : neg_reg;
        seen_base = item.start_req ? 1'b0 : seen_reg;
        acc_base  = item.start_req ? '0 : acc_reg;
        pos_base  = item.start_req ? '0 : pos_reg;

        product   = acc_base * act.base_value;
        neg_next  = neg_base | act.set_neg;
        base_next = act.base_value;
        acc_next  = act.accumulate
                  ? product[aip_pkg::VALUE_WIDTH-1:0] + aip_pkg::VALUE_WIDTH'(dg.value)
                  : acc_base;
        seen_next = seen_base | act.accumulate;
        if (act.bump && pos_base != {POSITION_WIDTH{1'b1}})
        begin
            pos_next = pos_base + POSITION_WIDTH'(1);
        end
        else
        begin
            pos_next = pos_base;
        end

        pos_wide     = 32'(pos_base);
        result_valid = act.finish_zero | act.finish_acc;
        if (act.finish_zero)
        begin
            result = '0;
        end
        else
        begin
            result.value      = neg_base ? ('0 - acc_base) : acc_base;
            result.end_offset = (pos_wide > 32'(aip_pkg::OFFSET_MAX))
                              ? aip_pkg::OFFSET_MAX
                              : pos_wide[aip_pkg::OFFSET_WIDTH-1:0];
            result.converted  = seen_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aip_pkg::PH_IDLE;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            acc_reg   <= '0;
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
        end
    end

    // A character with no string open never produces a result.
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !item.start_req && phase_reg == aip_pkg::PH_IDLE |-> !result_valid)
        else $error("result produced with no string open");

    // After a result the string is closed.
    a_close_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result_valid |=> phase_reg == aip_pkg::PH_IDLE)
        else $error("phase not idle after result");

    // A converted number has consumed at least one character; an
    // unconverted one has value zero.
    a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.converted ? (result.end_offset != '0)
                                           : (result.value == '0)))
        else $error("result fields inconsistent with converted flag");

endmodule

// ----- tb/ascii_integer_parser_top_tb.sv -----
// Testbench for ascii_integer_parser_top: strings of characters are streamed
// in and every parsed number is checked against a predictor kept in this file.
// Depends on aip_pkg and the parser RTL only.
`timescale 1ns / 1ps

module ascii_integer_parser_top_tb;

    localparam int POS_W = 16;

    // Receiver stall patterns, switched every so often.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_pattern_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] ch
    logic [0:0]  s_axis_tuser = '0;     // [0] start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // [63:0] value, [79:64] end_offset
    logic [0:0]  m_axis_tuser;          // [0] converted

    ascii_integer_parser_top #(
        .POSITION_WIDTH(POS_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Characters waiting to be sent and the numbers the parser owes us.
    aip_pkg::aip_item_t   char_backlog[$];
    aip_pkg::aip_result_t expected_numbers[$];
    bit                   next_is_start = 1'b0;

    int unsigned failures = 0;
    int unsigned numbers_checked = 0;
    int unsigned chars_accepted = 0;
    int unsigned radix_writes = 0;

    // Shadow of the parser: the radix register and the per-string state.
    logic [5:0]           cfg_radix = aip_pkg::BASE_DEC;
    aip_pkg::aip_phase_t  phase = aip_pkg::PH_IDLE;
    logic                 negative = 1'b0;
    logic [5:0]           radix = '0;
    logic [63:0]          accum = '0;
    logic [POS_W-1:0]     position = '0;
    logic                 digit_seen = 1'b0;

    // Value of an alphanumeric character, 99 for anything else.
    function automatic int unsigned char_digit(input logic [7:0] c);
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE)
        begin
            return c - aip_pkg::CH_ZERO;
        end
        if (c >= aip_pkg::CH_LOWER_A && c <= aip_pkg::CH_LOWER_Z)
        begin
            return c - aip_pkg::CH_LOWER_A + 10;
        end
        if (c >= aip_pkg::CH_UPPER_A && c <= aip_pkg::CH_UPPER_Z)
        begin
            return c - aip_pkg::CH_UPPER_A + 10;
        end
        return 99;
    endfunction

    function automatic void bump_position();
        if (position != '1)
        begin
            position++;
        end
    endfunction

    // Advances the shadow parser by one character. Returns 1 when the
    // character closes a number, with the expected result in num.
    function automatic bit parse_char(input aip_pkg::aip_item_t it,
                                      output aip_pkg::aip_result_t num);
        int unsigned d;
        num = '0;
        if (it.start_req)
        begin
            phase      = aip_pkg::PH_SIGN;
            negative   = 1'b0;
            radix      = cfg_radix;
            accum      = '0;
            position   = '0;
            digit_seen = 1'b0;
        end
        if (phase == aip_pkg::PH_SIGN)
        begin
            phase = aip_pkg::PH_PREFIX;
            if (it.ch == aip_pkg::CH_PLUS || it.ch == aip_pkg::CH_MINUS)
            begin
                negative = (it.ch == aip_pkg::CH_MINUS);
                bump_position();
                return 1'b0;
            end
        end
        if (phase == aip_pkg::PH_PREFIX)
        begin
            if (radix != aip_pkg::BASE_AUTO)
            begin
                phase = aip_pkg::PH_DIGITS;
            end
            else if (it.ch == aip_pkg::CH_ZERO)
            begin
                bump_position();
                phase = aip_pkg::PH_ZERO;
                return 1'b0;
            end
            else if (it.ch >= aip_pkg::CH_ONE && it.ch <= aip_pkg::CH_NINE)
            begin
                radix = aip_pkg::BASE_DEC;
                phase = aip_pkg::PH_DIGITS;
            end
            else
            begin
                // Radix detection found no digit: nothing consumed.
                phase = aip_pkg::PH_IDLE;
                return 1'b1;
            end
        end
        if (phase == aip_pkg::PH_ZERO)
        begin
            phase = aip_pkg::PH_DIGITS;
            if (it.ch == aip_pkg::CH_LOWER_X || it.ch == aip_pkg::CH_UPPER_X)
            begin
                radix = aip_pkg::BASE_HEX;
                bump_position();
                return 1'b0;
            end
            radix = aip_pkg::BASE_OCT;
        end
        if (phase == aip_pkg::PH_DIGITS)
        begin
            d = char_digit(it.ch);
            if (d < radix)
            begin
                accum      = accum * 64'(radix) + 64'(d);
                digit_seen = 1'b1;
                bump_position();
                return 1'b0;
            end
            num.value      = negative ? -accum : accum;
            num.end_offset = (32'(position) > 32'(aip_pkg::OFFSET_MAX))
                           ? aip_pkg::OFFSET_MAX
                           : aip_pkg::OFFSET_WIDTH'(position);
            num.converted  = digit_seen;
            phase          = aip_pkg::PH_IDLE;
            return 1'b1;
        end
        phase = aip_pkg::PH_IDLE;
        return 1'b0;
    endfunction

    function automatic void note_failure(input string msg);
        if (failures < 10)
        begin
            $display("%t mismatch: %s", $realtime, msg);
        end
        failures++;
    endfunction

    function automatic void push_char(input logic [7:0] c);
        aip_pkg::aip_item_t it;
        it.ch         = c;
        it.start_req  = next_is_start;
        next_is_start = 1'b0;
        char_backlog.push_back(it);
    endfunction

    function automatic void push_text(input string s);
        foreach (s[i])
        begin
            push_char(s[i]);
        end
    endfunction

    // A character that is a valid digit below the given radix (capped at 36).
    function automatic logic [7:0] random_digit(input int unsigned eff);
        int unsigned v;
        v = $urandom_range(0, eff - 1);
        if (v < 10)
        begin
            return 8'(aip_pkg::CH_ZERO + v);
        end
        return 8'(($urandom_range(0, 1) ? aip_pkg::CH_LOWER_A : aip_pkg::CH_UPPER_A) + v - 10);
    endfunction

    // One random string. Most are well formed (sign, prefix, digits, closing
    // character); the rest are noise, abandoned strings or failed detection.
    function automatic void queue_random_string(input logic [5:0] rdx);
        int unsigned eff;
        int unsigned ndig;
        int unsigned sgn;
        int unsigned pfx;
        logic [7:0]  c;
        next_is_start = 1'b1;
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
            return;
        end
        sgn = $urandom_range(0, 2);
        if (sgn == 1)
        begin
            push_char(aip_pkg::CH_PLUS);
        end
        else if (sgn == 2)
        begin
            push_char(aip_pkg::CH_MINUS);
        end
        eff = (rdx > 36) ? 36 : rdx;
        if (rdx == aip_pkg::BASE_AUTO)
        begin
            pfx = $urandom_range(0, 3);
            case (pfx)
                0:
                begin
                    push_char(aip_pkg::CH_ZERO);
                    push_char($urandom_range(0, 1) ? aip_pkg::CH_LOWER_X : aip_pkg::CH_UPPER_X);
                    eff = aip_pkg::BASE_HEX;
                end
                1:
                begin
                    push_char(aip_pkg::CH_ZERO);
                    eff = aip_pkg::BASE_OCT;
                end
                2:
                begin
                    push_char(8'(aip_pkg::CH_ZERO + $urandom_range(1, 9)));
                    eff = aip_pkg::BASE_DEC;
                end
                default:
                begin
                    // Detection sees no decimal digit after the sign.
                    do c = 8'($urandom_range(0, 255)); while (char_digit(c) < 10);
                    push_char(c);
                    return;
                end
            endcase
        end
        ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
        repeat (ndig) push_char(random_digit(eff));
        // Sometimes the string is left open and the next start abandons it.
        if ($urandom_range(0, 9) == 0)
        begin
            return;
        end
        do c = 8'($urandom_range(0, 255)); while (char_digit(c) < eff);
        push_char(c);
        // Characters after the close are dropped by the parser.
        repeat ($urandom_range(0, 2)) push_char(8'($urandom_range(0, 255)));
    endfunction

    // Returns once every queued character is taken, every number has come
    // back, and the pipeline has had time to settle.
    task automatic wait_parser_drained();
        while (char_backlog.size() != 0 || s_axis_tvalid || expected_numbers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_radix(input logic [5:0] r);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        cfg_radix = r;
        radix_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender: bursts of back-to-back requests separated by random gaps. The
    // predictor runs here, on each character at the edge it is accepted.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : feed_chars
        aip_pkg::aip_item_t   it;
        aip_pkg::aip_result_t num;
        logic                 nxt_valid;
        logic [7:0]           nxt_data;
        logic                 nxt_start;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            nxt_valid = s_axis_tvalid;
            nxt_data  = s_axis_tdata;
            nxt_start = s_axis_tuser[0];
            if (s_axis_tvalid && s_axis_tready)
            begin
                chars_accepted++;
                it.ch        = s_axis_tdata;
                it.start_req = s_axis_tuser[0];
                if (parse_char(it, num))
                begin
                    expected_numbers.push_back(num);
                end
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (char_backlog.size() > 0)
                begin
                    it        = char_backlog.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data  = it.ch;
                    nxt_start = it.start_req;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 23);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_axis_tvalid   <= nxt_valid;
            s_axis_tdata    <= nxt_data;
            s_axis_tuser[0] <= nxt_start;
        end
    end

    // Receiver: ready follows one of several patterns for a random stretch.
    rx_pattern_t rx_pattern = RX_ALWAYS;
    int unsigned rx_left = 0;
    int unsigned rx_tick = 0;

    always @(posedge clk or negedge rst_n)
    begin : drain_results
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                rx_left    = $urandom_range(16, 200);
            end
            else
            begin
                rx_left--;
            end
            rx_tick++;
            case (rx_pattern)
                RX_ALWAYS:   m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:     m_axis_tready <= ((rx_tick % 8) < 5);
            endcase
        end
    end

    // Checker: every accepted result against the oldest expected number.
    always @(posedge clk)
    begin : check_numbers
        aip_pkg::aip_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_numbers.size() == 0)
            begin
                note_failure($sformatf("unexpected result value %0d offset %0d converted %0b",
                    $signed(m_axis_tdata[63:0]), m_axis_tdata[79:64], m_axis_tuser[0]));
            end
            else
            begin
                want = expected_numbers.pop_front();
                numbers_checked++;
                if (m_axis_tdata[63:0] !== want.value || m_axis_tdata[79:64] !== want.end_offset
                    || m_axis_tuser[0] !== want.converted)
                begin
                    note_failure($sformatf(
                        "expected value %0d offset %0d converted %0b, got %0d %0d %0b",
                        $signed(want.value), want.end_offset, want.converted,
                        $signed(m_axis_tdata[63:0]), m_axis_tdata[79:64], m_axis_tuser[0]));
                end
            end
        end
    end

    // Stimulus sequence. Radix changes happen only with the parser drained.
    initial
    begin : run_phases
        logic [5:0]  plan[14];
        int unsigned phase_start;
        plan = '{aip_pkg::BASE_AUTO, 6'd36, aip_pkg::BASE_DEC, aip_pkg::BASE_HEX, 6'd2,
                 6'd63, aip_pkg::BASE_AUTO, aip_pkg::BASE_OCT, 6'd37,
                 6'($urandom_range(3, 35)), 6'($urandom_range(38, 62)), aip_pkg::BASE_AUTO,
                 6'd1, 6'd36};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings at the reset radix of ten.
        push_char("q");                         // no string open, dropped
        next_is_start = 1'b1; push_text("-123!");
        next_is_start = 1'b1; push_text("+x");  // sign with no digit
        next_is_start = 1'b1; push_text("45");  // abandoned by the restart
        next_is_start = 1'b1; push_text("7"); push_char(8'hFF);
        next_is_start = 1'b1; push_text("9"); push_char(8'h00);
        wait_parser_drained();

        // Directed strings with radix detection.
        write_radix(aip_pkg::BASE_AUTO);
        next_is_start = 1'b1; push_text("0x1F"); push_char(8'h00);
        next_is_start = 1'b1; push_text("0xg"); // empty hex
        next_is_start = 1'b1; push_text("-017~");
        next_is_start = 1'b1; push_text("+z");  // detection fails
        wait_parser_drained();

        // Radix one accepts only zeros.
        write_radix(6'd1);
        next_is_start = 1'b1;
        push_text("-0000001#");
        wait_parser_drained();

        foreach (plan[p])
        begin
            write_radix(plan[p]);
            phase_start = char_backlog.size();
            while (char_backlog.size() - phase_start < 95)
            begin
                queue_random_string(plan[p]);
            end
            wait_parser_drained();
        end

        repeat (10) @(posedge clk);
        if (expected_numbers.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", expected_numbers.size()));
        end
        $display("Covered %0d characters and %0d parsed numbers over %0d radix writes,",
            chars_accepted, numbers_checked, radix_writes);
        $display("including auto-detection, radix 1, radix 63 and receiver stalls.");
        if (failures == 0)
        begin
            $display("[ascii_integer_parser_top] OK");
        end
        else
        begin
            $display("[ascii_integer_parser_top] ERROR");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin : watchdog
        #20_000_000;
        $display("Timeout with %0d results outstanding.", expected_numbers.size());
        $display("[ascii_integer_parser_top] ERROR");
        $finish;
    end

endmodule
